@@ src/rcadj_pkg.sv @@
// Shared types, constants and helper functions of the channel adjustment slot.
package rcadj_pkg;

  localparam int NOW_W  = 32;
  localparam int CH_W   = 12;
  localparam int VAL_W  = 16;
  localparam int STEP_W = 8;
  localparam int RNG_W  = 12;
  localparam int CFG_IDX_W = 3;
  // Candidate value before clamping: slot_min plus a mapped quotient of up to 24 bits.
  localparam int CAND_W = 26;
  // Divider operand widths: mapping numerator magnitude, and twice the slot width.
  localparam int DVD_W  = 28;
  localparam int DSR_W  = 17;
  localparam int PROD_W = 29;
  localparam int MRG_W  = 10;

  localparam logic [NOW_W-1:0] REPEAT_MS  = 32'd500;
  localparam logic [NOW_W-1:0] TRIGGER_MS = 32'd100;

  localparam logic [CH_W-1:0]  CH_BASE    = 12'd900;
  localparam logic [CH_W-1:0]  CH_TOP     = 12'd2099;
  localparam logic [CH_W-1:0]  MOVE_LIMIT = 12'd2;
  localparam logic [MRG_W-1:0] MIN_MARGIN = 10'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_SIZE  = 3'd0,
    CFG_RANGE_ONE  = 3'd1,
    CFG_RANGE_TWO  = 3'd2,
    CFG_SLOT_MIN   = 3'd3,
    CFG_SLOT_MAX   = 3'd4,
    CFG_FUNC_MIN   = 3'd5,
    CFG_FUNC_MAX   = 3'd6,
    CFG_INIT_VALUE = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [STEP_W-1:0] step_size;
    logic [RNG_W-1:0]  range_one;
    logic [RNG_W-1:0]  range_two;
    logic [VAL_W-1:0]  slot_min;
    logic [VAL_W-1:0]  slot_max;
    logic [VAL_W-1:0]  func_min;
    logic [VAL_W-1:0]  func_max;
    logic [VAL_W-1:0]  initial_value;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Channel value of a step: 900 + 25 * step.
  function automatic logic [CH_W-1:0] step_value(input logic [5:0] s);
    return CH_BASE + CH_W'({s, 4'b0000}) + CH_W'({s, 3'b000}) + CH_W'(s);
  endfunction

  function automatic logic in_range(input logic [RNG_W-1:0] rng, input logic [CH_W-1:0] ch);
    logic [CH_W-1:0] c;
    c = ch;
    if (c < CH_BASE) c = CH_BASE;
    if (c > CH_TOP)  c = CH_TOP;
    return (rng[11:6] < rng[5:0]) && (c >= step_value(rng[11:6])) &&
           (c < step_value(rng[5:0]));
  endfunction

  // Wrap-safe: now lies before mark when the signed difference is negative.
  function automatic logic time_before(input logic [NOW_W-1:0] now,
                                       input logic [NOW_W-1:0] mark);
    logic [NOW_W-1:0] d;
    d = now - mark;
    return d[NOW_W-1];
  endfunction

  function automatic logic signed [CAND_W-1:0] sext_cand(input logic [VAL_W-1:0] v);
    return $signed({{(CAND_W-VAL_W){v[VAL_W-1]}}, v});
  endfunction

  // Low limit first, then high limit.
  function automatic logic signed [CAND_W-1:0] clamp_cand(input logic signed [CAND_W-1:0] v,
                                                          input logic [VAL_W-1:0] lo,
                                                          input logic [VAL_W-1:0] hi);
    logic signed [CAND_W-1:0] lo_s;
    logic signed [CAND_W-1:0] hi_s;
    lo_s = sext_cand(lo);
    hi_s = sext_cand(hi);
    if (v < lo_s) return lo_s;
    if (v > hi_s) return hi_s;
    return v;
  endfunction

endpackage

@@ src/rcadj_cfg.sv @@
// Configuration register file of the channel adjustment slot.
module rcadj_cfg
  import rcadj_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [VAL_W-1:0]     wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        CFG_STEP_SIZE:  cfg_r.step_size     <= wr_data[STEP_W-1:0];
        CFG_RANGE_ONE:  cfg_r.range_one     <= wr_data[RNG_W-1:0];
        CFG_RANGE_TWO:  cfg_r.range_two     <= wr_data[RNG_W-1:0];
        CFG_SLOT_MIN:   cfg_r.slot_min      <= wr_data;
        CFG_SLOT_MAX:   cfg_r.slot_max      <= wr_data;
        CFG_FUNC_MIN:   cfg_r.func_min      <= wr_data;
        CFG_FUNC_MAX:   cfg_r.func_max      <= wr_data;
        CFG_INIT_VALUE: cfg_r.initial_value <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ src/rcadj_div.sv @@
// Shared restoring divider: one quotient bit per cycle.
module rcadj_div
  import rcadj_pkg::*;
#(
  parameter int DIVIDEND_W = DVD_W,
  parameter int DIVISOR_W  = DSR_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output div_stat_t             stat,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  run_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  dsr_r;

  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    rem_sub;
  logic                  fits;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DIVIDEND_W-1]};
    rem_sub = rem_sh - {1'b0, dsr_r};
    fits    = (rem_sh >= {1'b0, dsr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      cnt_r <= CNT_W'(DIVIDEND_W);
    end else if (run_r) begin
      if (cnt_r == '0) begin
        run_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (run_r && (cnt_r != '0)) begin
      rem_r <= fits ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      quo_r <= {quo_r[DIVIDEND_W-2:0], fits};
    end
  end

  assign stat.busy = run_r;
  assign stat.done = run_r && (cnt_r == '0);
  assign quotient  = quo_r;

endmodule

@@ src/rc_channel_adjust_slot_top.sv @@
// Top level of the channel adjustment slot: sequencer, slot state and ports.
//
//  channel | ports                               | word
//  --------+-------------------------------------+----------------------------------------
//  in      | in_tvalid/in_tready/in_tdata/in_tuser | now_ms, channel_value, current_value;
//          |                                     | tuser: signal_ok, enable_active
//  out     | out_tvalid/out_tready/out_tdata/out_tuser | new_value; tuser: changed
//  cfg     | cfg_valid/cfg_ready/cfg_index/cfg_data | register index, write data
//
// One word at a time; in_tready is high only while the sequencer idles. An early exit
// (no signal, disabled, dead time, channel moved, timer running, no band hit) goes from
// evaluation straight to the finishing state; a stepped step or an unmappable continuous
// word passes the function clamp and then the slot clamp first. Continuous mode runs the
// shared 28-bit divider for the margin, and inside the widened band again for the mapping,
// before both clamps. The sequencer idles again as the result enters the output register.
// Reset (rst_n low, synchronous) clears configuration, slot state and the sequencer.
// A stalled result sits in the output register; the next word is accepted meanwhile
// and waits at its result until the register frees. cfg_ready is always high.
module rc_channel_adjust_slot_top
  import rcadj_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [63:0]          in_tdata,   // now_ms[31:0], channel_value[43:32],
                                           // current_value[59:44], zero[63:60]
  input  logic [1:0]           in_tuser,   // signal_ok[0], enable_active[1]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,  // new_value[15:0]
  output logic [0:0]           out_tuser,  // changed[0]
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MARGIN,
    ST_MAPDIV,
    ST_CLAMP_FN,
    ST_CLAMP_SLOT,
    ST_DONE
  } state_t;

  cfg_t      cfg;
  div_stat_t div_stat;
  logic      div_start;
  logic [DVD_W-1:0] div_dividend;
  logic [DSR_W-1:0] div_divisor;
  logic [DVD_W-1:0] div_quotient;

  state_t st_r, st_nxt;
  logic [NOW_W-1:0] now_r, now_nxt;
  logic [CH_W-1:0]  ch_r, ch_nxt;
  logic             sig_r, sig_nxt;
  logic             ena_r, ena_nxt;
  logic [VAL_W-1:0] cur_r, cur_nxt;
  logic [NOW_W-1:0] dead_until_r, dead_until_nxt;
  logic [NOW_W-1:0] trigger_at_r, trigger_at_nxt;
  logic [VAL_W-1:0] last_value_r, last_value_nxt;
  logic [CH_W-1:0]  last_channel_r, last_channel_nxt;
  logic signed [CAND_W-1:0] cand_r, cand_nxt;
  logic             chk_r, chk_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic             neg_r, neg_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_changed_r, out_changed_nxt;
  logic [VAL_W-1:0] out_value_r, out_value_nxt;

  logic cfg_wr;
  logic in_acc;
  logic out_free;

  // Mapping geometry from range one and the slot limits.
  logic [CH_W-1:0]        lower, upper;
  logic                   rw_ok;
  logic [10:0]            rw;
  logic signed [VAL_W:0]  vw_full;
  logic                   vw_ok;
  logic signed [12:0]     ch_diff;
  logic signed [29:0]     prod_full;
  logic [MRG_W-1:0]       margin;
  logic                   win;
  logic signed [PROD_W-1:0] num;
  logic [PROD_W-1:0]      num_mag;
  logic [CH_W-1:0]        ch_move;
  logic signed [CAND_W-1:0] q_ext;
  logic                   changed;

  rcadj_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_wr),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  rcadj_div #(
    .DIVIDEND_W (DVD_W),
    .DIVISOR_W  (DSR_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quotient)
  );

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_tready = (st_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    lower     = step_value(cfg.range_one[11:6]);
    upper     = step_value(cfg.range_one[5:0]);
    rw_ok     = cfg.range_one[11:6] < cfg.range_one[5:0];
    rw        = 11'(upper - lower);
    vw_full   = $signed({cfg.slot_max[VAL_W-1], cfg.slot_max}) -
                $signed({cfg.slot_min[VAL_W-1], cfg.slot_min});
    vw_ok     = !vw_full[VAL_W] && (vw_full != '0);
    ch_diff   = $signed({1'b0, ch_r}) - $signed({1'b0, lower});
    prod_full = ch_diff * $signed({1'b0, vw_full[VAL_W-1:0]});
    // Margin is rw / (2 * vw), raised to the minimum.
    margin    = (div_quotient < DVD_W'(MIN_MARGIN)) ? MIN_MARGIN : div_quotient[MRG_W-1:0];
    win       = ({1'b0, ch_r} + {3'b000, margin} > {1'b0, lower}) &&
                ({1'b0, ch_r} < {1'b0, upper} + {3'b000, margin});
    num       = prod_r + $signed(PROD_W'(rw >> 1));
    num_mag   = num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
    ch_move   = (ch_r >= last_channel_r) ? (ch_r - last_channel_r) : (last_channel_r - ch_r);
    q_ext     = $signed(CAND_W'(div_quotient));
    changed   = chk_r && (cand_r[VAL_W-1:0] != last_value_r);
  end

  always_comb begin
    st_nxt           = st_r;
    now_nxt          = now_r;
    ch_nxt           = ch_r;
    sig_nxt          = sig_r;
    ena_nxt          = ena_r;
    cur_nxt          = cur_r;
    dead_until_nxt   = dead_until_r;
    trigger_at_nxt   = trigger_at_r;
    last_value_nxt   = last_value_r;
    last_channel_nxt = last_channel_r;
    cand_nxt         = cand_r;
    chk_nxt          = chk_r;
    prod_nxt         = prod_r;
    neg_nxt          = neg_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    out_changed_nxt  = out_changed_r;
    out_value_nxt    = out_value_r;
    div_start        = 1'b0;
    div_dividend     = DVD_W'(rw);
    div_divisor      = {vw_full[VAL_W-1:0], 1'b0};

    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          now_nxt = in_tdata[31:0];
          ch_nxt  = in_tdata[43:32];
          cur_nxt = in_tdata[59:44];
          sig_nxt = in_tuser[0];
          ena_nxt = in_tuser[1];
          st_nxt  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        chk_nxt  = 1'b0;
        cand_nxt = sext_cand(last_value_r);
        st_nxt   = ST_DONE;
        if (sig_r && ena_r && !time_before(now_r, dead_until_r)) begin
          if (cfg.step_size != '0) begin
            if (ch_move > MOVE_LIMIT) begin
              // Re-arm the settle timer and track the new reading.
              trigger_at_nxt   = now_r + TRIGGER_MS;
              last_channel_nxt = ch_r;
            end else if (!time_before(now_r, trigger_at_r)) begin
              if (in_range(cfg.range_one, ch_r)) begin
                cand_nxt = sext_cand(cur_r) - $signed(CAND_W'(cfg.step_size));
                chk_nxt  = 1'b1;
                st_nxt   = ST_CLAMP_FN;
              end else if (in_range(cfg.range_two, ch_r)) begin
                cand_nxt = sext_cand(cur_r) + $signed(CAND_W'(cfg.step_size));
                chk_nxt  = 1'b1;
                st_nxt   = ST_CLAMP_FN;
              end
            end
          end else begin
            chk_nxt  = 1'b1;
            prod_nxt = prod_full[PROD_W-1:0];
            if (rw_ok && vw_ok) begin
              div_start = 1'b1;
              st_nxt    = ST_MARGIN;
            end else begin
              st_nxt    = ST_CLAMP_FN;
            end
          end
        end
      end
      ST_MARGIN: begin
        if (div_stat.done) begin
          if (win) begin
            // Divide the magnitude and restore the sign: truncation toward zero.
            div_start    = 1'b1;
            div_dividend = num_mag[DVD_W-1:0];
            div_divisor  = DSR_W'(rw);
            neg_nxt      = num[PROD_W-1];
            st_nxt       = ST_MAPDIV;
          end else begin
            st_nxt = ST_CLAMP_FN;
          end
        end
      end
      ST_MAPDIV: begin
        if (div_stat.done) begin
          cand_nxt = sext_cand(cfg.slot_min) + (neg_r ? -q_ext : q_ext);
          st_nxt   = ST_CLAMP_FN;
        end
      end
      ST_CLAMP_FN: begin
        cand_nxt = clamp_cand(cand_r, cfg.func_min, cfg.func_max);
        st_nxt   = ST_CLAMP_SLOT;
      end
      ST_CLAMP_SLOT: begin
        cand_nxt = clamp_cand(cand_r, cfg.slot_min, cfg.slot_max);
        st_nxt   = ST_DONE;
      end
      ST_DONE: begin
        // Hold here until the output register can take the result.
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_changed_nxt = changed;
          out_value_nxt   = changed ? cand_r[VAL_W-1:0] : '0;
          if (changed) begin
            last_value_nxt = cand_r[VAL_W-1:0];
            dead_until_nxt = now_r + REPEAT_MS;
          end
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase

    // Loading the initial value also resets the slot's last value.
    if (cfg_wr && (cfg_idx_t'(cfg_index) == CFG_INIT_VALUE)) begin
      last_value_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r           <= ST_IDLE;
      dead_until_r   <= '0;
      trigger_at_r   <= '0;
      last_value_r   <= '0;
      last_channel_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      st_r           <= st_nxt;
      dead_until_r   <= dead_until_nxt;
      trigger_at_r   <= trigger_at_nxt;
      last_value_r   <= last_value_nxt;
      last_channel_r <= last_channel_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    now_r         <= now_nxt;
    ch_r          <= ch_nxt;
    sig_r         <= sig_nxt;
    ena_r         <= ena_nxt;
    cur_r         <= cur_nxt;
    cand_r        <= cand_nxt;
    chk_r         <= chk_nxt;
    prod_r        <= prod_nxt;
    neg_r         <= neg_nxt;
    out_changed_r <= out_changed_nxt;
    out_value_r   <= out_value_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_value_r;
  assign out_tuser[0] = out_changed_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("sequencer still idle after accepting a word");

  a_div_only_when_mapping: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> (st_r == ST_MARGIN || st_r == ST_MAPDIV))
    else $error("divider running outside the mapping states");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(st_r == ST_DONE))
    else $error("result raised outside the finishing state");

  a_unchanged_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == '0))
    else $error("unchanged result carries a nonzero value");

endmodule
